>>> hw/rtl/distinct_color_collector_macros.svh
// ----------------------------------------------------------------------------
// Distinct color collector assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// held off while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_COLOR_COLLECTOR_MACROS_SVH
`define DISTINCT_COLOR_COLLECTOR_MACROS_SVH

// Plain property check.
`define DCC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that holds in the cycle after a trigger.
`define DCC_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// Distinct color collector package
// Field widths, function codes and sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package dcc_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned RGB_W   = 3 * CHAN_W;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PIXEL  = 2'd0,
    FUNC_PAL_WR = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAL  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/dcc_intf.sv
// ----------------------------------------------------------------------------
// Distinct color collector channels
// Valid/ready interfaces for the pixel, result and configuration words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcc_pix_if;
  logic                        valid;
  logic                        ready;
  logic [dcc_pkg::FUNC_W-1:0]  func;
  logic [dcc_pkg::CHAN_W-1:0]  red;
  logic [dcc_pkg::CHAN_W-1:0]  green;
  logic [dcc_pkg::CHAN_W-1:0]  blue;
  logic [dcc_pkg::IDX_W-1:0]   palette_index;

  modport source (output valid, func, red, green, blue, palette_index, input ready);
  modport sink   (input valid, func, red, green, blue, palette_index, output ready);
endinterface

interface dcc_res_if;
  logic                         valid;
  logic                         ready;
  logic                         is_new;
  logic [dcc_pkg::SLOT_W-1:0]   color_slot;
  logic [dcc_pkg::COUNT_W-1:0]  color_count;
  logic                         overflow;

  modport source (output valid, is_new, color_slot, color_count, overflow, input ready);
  modport sink   (input valid, is_new, color_slot, color_count, overflow, output ready);
endinterface

interface dcc_cfg_if;
  logic valid;
  logic ready;
  logic pixel_mode;

  modport source (output valid, pixel_mode, input ready);
  modport sink   (input valid, pixel_mode, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dcc_ram.sv
// ----------------------------------------------------------------------------
// Distinct color collector RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/distinct_color_collector.sv
// ----------------------------------------------------------------------------
// Distinct color collector
// Keeps the distinct RGB colors of a pixel stream in first-seen order and
// reports slot, running count and a sticky overflow flag for every word.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                         accept
//   -------  ---  ----------------------------------------------  -------------
//   pix_i    in   func, red, green, blue, palette_index           valid & ready
//   res_o    out  is_new, color_slot, color_count, overflow       valid & ready
//   cfg_i    in   pixel_mode                                      valid & ready
//
// Timing: a pixel word runs a linear search through the color table RAM
//   read port, one stored color per cycle; in palette mode an in-range index
//   adds a palette read first. A hit ends the search early. Palette writes,
//   clears and unused codes skip the search.
// One word is worked on at a time; the next is taken while a result waits.
// Reset clears the count, overflow flag, mode and control; the RAMs hold
//   no reset value and need no clearing pass.
// res_o stalls only hold the finished result; the sequencer waits in its
//   result state until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "distinct_color_collector_macros.svh"

module distinct_color_collector #(
  parameter int unsigned MAX_COLORS   = 256,
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcc_cfg_if.sink    cfg_i,
  dcc_pix_if.sink    pix_i,
  dcc_res_if.source  res_o
);

  import dcc_pkg::*;

  localparam int unsigned TAW = $clog2(MAX_COLORS);     // table address
  localparam int unsigned CW  = $clog2(MAX_COLORS + 1); // count, 0..MAX
  localparam int unsigned PAW = $clog2(PALETTE_SIZE);   // palette address

  localparam logic [CW-1:0]    MAX_CNT = CW'(MAX_COLORS);
  localparam logic [IDX_W:0]   PAL_LIM = (IDX_W + 1)'(PALETTE_SIZE);

  state_e              state_q, state_d;
  logic [RGB_W-1:0]    color_q, color_d;      // color being searched
  logic [CW-1:0]       count_q, count_d;      // distinct colors stored
  logic [CW-1:0]       ptr_q, ptr_d;          // next table entry to read
  logic                pend_q, pend_d;        // read data due for compare
  logic [TAW-1:0]      cmp_addr_q, cmp_addr_d;
  logic                ovf_q, ovf_d;
  logic                mode_q, mode_d;
  logic                is_new_q, is_new_d;
  logic [TAW-1:0]      slot_q, slot_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic                out_is_new_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_ovf_q;

  logic                accept;
  logic                pal_in_range;
  logic                pal_we, pal_re;
  logic [RGB_W-1:0]    pal_rdata;
  logic                tbl_we, tbl_re;
  logic [RGB_W-1:0]    tbl_rdata;
  logic                found;
  logic                scan_end;
  logic [RGB_W-1:0]    pix_rgb;
  logic [TAW+SLOT_W-1:0] slot_ext;
  logic [CW+COUNT_W-1:0] count_ext;

  // --------------------------------------------------------------------------
  // Handshakes and memory strobes
  // --------------------------------------------------------------------------
  assign cfg_i.ready  = 1'b1;
  assign pix_i.ready  = (state_q == ST_IDLE);
  assign accept       = pix_i.valid && pix_i.ready;
  assign pix_rgb      = {pix_i.red, pix_i.green, pix_i.blue};
  assign pal_in_range = ({1'b0, pix_i.palette_index} < PAL_LIM);

  // Palette: written by palette-write words, read once for palette pixels.
  assign pal_we = accept && (func_e'(pix_i.func) == FUNC_PAL_WR) && pal_in_range;
  assign pal_re = accept && (func_e'(pix_i.func) == FUNC_PIXEL) && mode_q && pal_in_range;

  // Search: read entry ptr, compare it in the next cycle against the color.
  assign found    = (state_q == ST_SCAN) && pend_q && (tbl_rdata == color_q);
  assign scan_end = (state_q == ST_SCAN) && !found && (ptr_q == count_q);
  assign tbl_re   = (state_q == ST_SCAN) && !found && (ptr_q != count_q);
  // Append on a miss while room is left.
  assign tbl_we   = scan_end && (count_q != MAX_CNT);

  dcc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_SIZE)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pix_i.palette_index[PAW-1:0]),
    .wdata_i (pix_rgb),
    .re_i    (pal_re),
    .raddr_i (pix_i.palette_index[PAW-1:0]),
    .rdata_o (pal_rdata)
  );

  dcc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_COLORS)
  ) u_color_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[TAW-1:0]),
    .wdata_i (color_q),
    .re_i    (tbl_re),
    .raddr_i (ptr_q[TAW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    color_d    = color_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    pend_d     = 1'b0;
    cmp_addr_d = cmp_addr_q;
    ovf_d      = ovf_q;
    is_new_d   = is_new_q;
    slot_d     = slot_q;
    mode_d     = mode_q;
    out_load   = 1'b0;

    // Config writes must arrive only while idle; the block does not enforce it.
    if (cfg_i.valid) begin
      mode_d = cfg_i.pixel_mode;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          is_new_d = 1'b0;
          slot_d   = '0;
          ptr_d    = '0;
          case (func_e'(pix_i.func))
            FUNC_PIXEL: begin
              if (!mode_q) begin
                color_d = pix_rgb;
                state_d = ST_SCAN;
              end else if (pal_in_range) begin
                state_d = ST_PAL;
              end else begin
                // index beyond the palette reads as black
                color_d = '0;
                state_d = ST_SCAN;
              end
            end
            FUNC_PAL_WR: begin
              state_d = ST_DONE;
            end
            FUNC_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_PAL: begin
        color_d = pal_rdata;
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        if (found) begin
          slot_d  = cmp_addr_q;
          state_d = ST_DONE;
        end else if (scan_end) begin
          if (count_q != MAX_CNT) begin
            slot_d   = count_q[TAW-1:0];
            count_d  = CW'(count_q + 1'b1);
            is_new_d = 1'b1;
          end else begin
            // table full: color dropped, slot stays zero
            ovf_d = 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          pend_d     = 1'b1;
          cmp_addr_d = ptr_q[TAW-1:0];
          ptr_d      = CW'(ptr_q + 1'b1);
        end
      end

      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      ovf_q       <= 1'b0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      ovf_q       <= ovf_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q    <= color_d;
    cmp_addr_q <= cmp_addr_d;
    is_new_q   <= is_new_d;
    slot_q     <= slot_d;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  assign slot_ext    = {{SLOT_W{1'b0}}, slot_q};
  assign count_ext   = {{COUNT_W{1'b0}}, count_q};
  assign out_valid_d = out_load || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_is_new_q <= is_new_q;
      out_slot_q   <= slot_ext[SLOT_W-1:0];
      out_count_q  <= count_ext[COUNT_W-1:0];
      out_ovf_q    <= ovf_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.is_new      = out_is_new_q;
  assign res_o.color_slot  = out_slot_q;
  assign res_o.color_count = out_count_q;
  assign res_o.overflow    = out_ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DCC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= MAX_CNT, "color count beyond table depth")
  `DCC_ASSERT_NEXT(a_append_count, clk_i, rst_ni, tbl_we, count_q == CW'($past(count_q) + 1'b1), "table append without count step")
  `DCC_ASSERT(a_read_below_count, clk_i, rst_ni, tbl_re |-> (ptr_q < count_q), "search read past stored colors")
  `DCC_ASSERT(a_ovf_when_full, clk_i, rst_ni, $rose(ovf_q) |-> (count_q == MAX_CNT), "overflow set with room in table")

endmodule

`default_nettype wire
